// ----- hw/rtl/bdhc_pkg.sv -----
// Package for the button debounce and hold classifier.
// Holds the timer width, register indexes, event codes, state type and load helper.
// No dependencies.
`default_nettype none

package bdhc_pkg;

    localparam int TIMER_WIDTH = 16;
    localparam int REG_WIDTH = 16;
    localparam int CFG_INDEX_WIDTH = 2;

    localparam logic [31:0] TIMER_MAX = 32'((64'd1 << TIMER_WIDTH) - 64'd1);

    localparam logic [CFG_INDEX_WIDTH-1:0] REG_ENABLE = 2'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_DEBOUNCE_TICKS = 2'd1;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_HOLD_TICKS = 2'd2;

    localparam logic [REG_WIDTH-1:0] DEBOUNCE_RESET = 16'd50;
    localparam logic [REG_WIDTH-1:0] HOLD_RESET = 16'd500;

    localparam logic [1:0] EV_PRESS = 2'd0;
    localparam logic [1:0] EV_HOLD = 2'd1;
    localparam logic [1:0] EV_RELEASE_SHORT = 2'd2;
    localparam logic [1:0] EV_RELEASE_LONG = 2'd3;

    typedef logic [TIMER_WIDTH-1:0] timer_t;

    typedef struct packed {
        logic   level;
        timer_t lockout_left;
        timer_t hold_left;
        logic   hold_armed;
    } bdhc_state_t;

    typedef struct packed {
        logic       valid;
        logic [1:0] code;
    } bdhc_event_t;

    // Countdown loads saturate to the largest value the timer can hold.
    function automatic timer_t timer_load(input logic [REG_WIDTH-1:0] v);
        logic [31:0] w;
        begin
            w = 32'(v);
            if (w > TIMER_MAX)
            begin
                return timer_t'(TIMER_MAX);
            end
            return timer_t'(w);
        end
    endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/bdhc_step.sv -----
// Next-state and event logic for one tick of the debouncer and hold classifier.
// Depends on bdhc_pkg.
`default_nettype none

module bdhc_step (
    input  wire bdhc_pkg::bdhc_state_t       state,
    input  wire                              raw_level,
    input  wire [bdhc_pkg::REG_WIDTH-1:0]    debounce_ticks,
    input  wire [bdhc_pkg::REG_WIDTH-1:0]    hold_ticks,
    output bdhc_pkg::bdhc_state_t            state_next,
    output bdhc_pkg::bdhc_event_t            ev
);
    import bdhc_pkg::*;

    timer_t lock_dec;
    timer_t hold_dec;
    logic   change;

    always_comb
    begin
        lock_dec = (state.lockout_left != '0) ? state.lockout_left - timer_t'(1)
                                              : state.lockout_left;
        hold_dec = (state.hold_armed && state.hold_left != '0)
                   ? state.hold_left - timer_t'(1) : state.hold_left;
        change = (raw_level != state.level) && (lock_dec == '0);

        state_next.level = state.level;
        state_next.lockout_left = lock_dec;
        state_next.hold_left = hold_dec;
        state_next.hold_armed = state.hold_armed;
        ev.valid = 1'b0;
        ev.code = EV_PRESS;

        priority if (change)
        begin
            state_next.level = raw_level;
            state_next.lockout_left = timer_load(debounce_ticks);
            ev.valid = 1'b1;
            if (raw_level)
            begin
                state_next.hold_left = timer_load(hold_ticks);
                state_next.hold_armed = 1'b1;
                ev.code = EV_PRESS;
            end
            else
            begin
                state_next.hold_armed = 1'b0;
                ev.code = state.hold_armed ? EV_RELEASE_SHORT : EV_RELEASE_LONG;
            end
        end
        else if (state.level && state.hold_armed && hold_dec == '0)
        begin
            state_next.hold_armed = 1'b0;
            ev.valid = 1'b1;
            ev.code = EV_HOLD;
        end
        else
        begin
            ev.valid = 1'b0;
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/button_debounce_hold_classifier_top.sv -----
// Top level of the button debounce and hold classifier.
// Depends on bdhc_pkg and bdhc_step.
//
// Each input beat is one time tick carrying the sampled button level. The
// block debounces the level and reports PRESS, HOLD, RELEASE_SHORT and
// RELEASE_LONG events, each as one output beat with the debounced level.
// Most ticks produce no output beat.
// Configuration is written through cfg_we, cfg_index and cfg_wdata: index
// 0 is enable, 1 is debounce_ticks, 2 is hold_ticks. The user must write it
// only while the block is idle; the block does not enforce this. An accepted
// input beat passes through one input register, then the tick logic feeding
// the output register. Throughput is one tick per cycle while the output is
// not stalled; the tick logic that updates the countdowns and the debounced
// level is combinational. When the receiver stalls, the output beat is held
// and the input register keeps one tick, after which in_stall rises until
// the output drains. Reset clears both registers, the debounce state and the
// configuration to disabled, 50 debounce ticks and 500 hold ticks.
`default_nettype none

module button_debounce_hold_classifier_top (
    input  wire                                    clk,
    input  wire                                    rst_n,
    input  wire                                    in_valid,
    output logic                                   in_stall,
    input  wire                                    raw_level,
    output logic                                   out_valid,
    input  wire                                    out_stall,
    output logic [1:0]                             event_code,
    output logic                                   level_now,
    input  wire                                    cfg_we,
    input  wire  [bdhc_pkg::CFG_INDEX_WIDTH-1:0]   cfg_index,
    input  wire  [bdhc_pkg::REG_WIDTH-1:0]         cfg_wdata
);
    import bdhc_pkg::*;

    logic                 enable_reg;
    logic [REG_WIDTH-1:0] debounce_reg;
    logic [REG_WIDTH-1:0] hold_reg;

    logic                 in_v_reg;
    logic                 in_level_reg;
    logic                 ov_reg;
    logic [1:0]           code_reg;
    logic                 level_out_reg;

    bdhc_state_t          state_reg;
    bdhc_state_t          state_next;
    bdhc_event_t          ev;
    logic                 adv;
    logic                 take;

    bdhc_step u_step (
        .state          (state_reg),
        .raw_level      (in_level_reg),
        .debounce_ticks (debounce_reg),
        .hold_ticks     (hold_reg),
        .state_next     (state_next),
        .ev             (ev)
    );

    assign adv = !ov_reg || !out_stall;
    assign take = in_v_reg && adv;
    assign in_stall = in_v_reg && !adv;

    assign out_valid = ov_reg;
    assign event_code = code_reg;
    assign level_now = level_out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg <= 1'b0;
            debounce_reg <= DEBOUNCE_RESET;
            hold_reg <= HOLD_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_ENABLE:         enable_reg <= cfg_wdata[0];
                REG_DEBOUNCE_TICKS: debounce_reg <= cfg_wdata;
                REG_HOLD_TICKS:     hold_reg <= cfg_wdata;
                default:            ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_v_reg <= 1'b0;
            ov_reg <= 1'b0;
            state_reg <= '0;
        end
        else
        begin
            if (!in_stall)
            begin
                in_v_reg <= in_valid;
            end
            if (adv)
            begin
                ov_reg <= take && enable_reg && ev.valid;
            end
            if (take && enable_reg)
            begin
                state_reg <= state_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (!in_stall && in_valid)
        begin
            in_level_reg <= raw_level;
        end
        if (adv)
        begin
            code_reg <= ev.code;
            level_out_reg <= state_next.level;
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/bdhc_checker.sv -----
// Port-level checks for the button debounce and hold classifier, with its bind.
// Depends on bdhc_pkg and button_debounce_hold_classifier_top.
`default_nettype none

module bdhc_checker (
    input wire       clk,
    input wire       rst_n,
    input wire       in_stall,
    input wire       out_valid,
    input wire       out_stall,
    input wire [1:0] event_code,
    input wire       level_now
);
    import bdhc_pkg::*;

    // A stalled output beat is held unchanged.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(event_code) && $stable(level_now))
        else $error("output beat changed while stalled");

    // Presses and holds report a pressed level, releases a released one.
    a_level_match: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (level_now == ((event_code == EV_PRESS) || (event_code == EV_HOLD))))
        else $error("debounced level does not match the event");

    // The input side only backs up behind a stalled output beat.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled without a stalled output beat");

    // Reset leaves no output beat behind.
    a_reset_empty: assert property (@(posedge clk)
        !rst_n |=> !out_valid)
        else $error("output beat present after reset");

endmodule

bind button_debounce_hold_classifier_top bdhc_checker u_bdhc_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_stall   (in_stall),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .event_code (event_code),
    .level_now  (level_now)
);

`default_nettype wire
